@@ hdl/dlr_pkg.sv @@
`timescale 1ns / 1ps

package dlr_pkg;

    // Coordinate width is fixed by the pixel and endpoint fields
    localparam int COORD_BITS = 12;
    // Default fraction width of the minor accumulator and slope
    localparam int FRAC_BITS  = 16;

    // Command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV
    } state_t;

    // Command beat
    typedef struct packed {
        logic                  cmd;
        logic [COORD_BITS-1:0] x_start;
        logic [COORD_BITS-1:0] y_start;
        logic [COORD_BITS-1:0] x_end;
        logic [COORD_BITS-1:0] y_end;
    } cmd_t;

    // Pixel beat
    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
        logic                  last;
    } pix_t;

    // Divider status seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

@@ hdl/dlr_divider.sv @@
`timescale 1ns / 1ps

module dlr_divider #(
    parameter int NUM_BITS = dlr_pkg::COORD_BITS + dlr_pkg::FRAC_BITS,
    parameter int DEN_BITS = dlr_pkg::COORD_BITS
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [NUM_BITS-1:0]     dividend,
    input  logic [DEN_BITS-1:0]     divisor,
    output dlr_pkg::div_status_t    status,
    output logic [NUM_BITS-1:0]     quotient
);

    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [DEN_BITS-1:0] rem_reg, rem_next;
    logic [NUM_BITS-1:0] quo_reg, quo_next;
    logic [DEN_BITS-1:0] den_reg, den_next;

    logic [DEN_BITS:0]   shifted;
    logic [DEN_BITS:0]   diff;
    logic                fits;

    // Trial subtract of one quotient bit
    always_comb
    begin
        shifted = {rem_reg, quo_reg[NUM_BITS-1]};
        diff    = shifted - {1'b0, den_reg};
        fits    = ~diff[DEN_BITS];
    end

    // Advance the restoring division one bit per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_BITS'(NUM_BITS);
            rem_next  = '0;
            quo_next  = dividend;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DEN_BITS-1:0] : shifted[DEN_BITS-1:0];
            quo_next = {quo_reg[NUM_BITS-2:0], fits};
            cnt_next = cnt_reg - CNT_BITS'(1);
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Hold working values
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule

@@ hdl/dda_line_rasterizer.sv @@
`timescale 1ns / 1ps

// DDA line generator. A start beat loads two endpoints, picks the major
// axis (x only when its distance is strictly larger), orders the endpoints
// so the major coordinate rises and computes the slope minor/major with
// FRAC_BITS fraction bits, truncated toward zero. The slope comes from a
// restoring divider that yields one quotient bit per cycle, so after a
// start beat cmd_stall stays high through the prep and divide states, or
// through the prep state alone for a zero-length line. Each step beat
// then returns one pixel through an output register, so a line streams
// at one pixel per clock while pix_stall is low. The minor coordinate is
// floor(accumulator + 1/2), and the final pixel carries last. A step with
// no line in progress returns nothing; a start beat aborts any line in
// progress.
module dda_line_rasterizer #(
    parameter int FRAC_BITS = dlr_pkg::FRAC_BITS
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  dlr_pkg::cmd_t cmd_data,
    output logic          pix_valid,
    input  logic          pix_stall,
    output dlr_pkg::pix_t pix_data
);

    localparam int CB      = dlr_pkg::COORD_BITS;
    localparam int NUM_W   = CB + FRAC_BITS;
    localparam int ACC_W   = CB + FRAC_BITS + 1;
    localparam logic [ACC_W:0] HALF = (ACC_W + 1)'(1) << (FRAC_BITS - 1);

    dlr_pkg::state_t state_reg, state_next;

    logic             line_active_reg, line_active_next;
    logic             pix_valid_reg, pix_valid_next;
    dlr_pkg::pix_t    pix_data_reg, pix_data_next;
    logic             x_major_reg, x_major_next;
    logic [CB-1:0]    major_pos_reg, major_pos_next;
    logic [CB-1:0]    major_end_reg, major_end_next;
    logic [CB-1:0]    min0_reg, min0_next;
    logic [CB-1:0]    min1_reg, min1_next;
    logic             neg_reg, neg_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [ACC_W-1:0] slope_reg, slope_next;

    logic             accept;
    logic             div_start;
    logic [NUM_W-1:0] div_dividend;
    logic [NUM_W-1:0] div_quotient;
    dlr_pkg::div_status_t div_status;

    logic [CB:0]      dx, dy, adx, ady;
    logic             x_major_in;
    logic [CB-1:0]    maj0, maj1, mn0, mn1;
    logic             swap;
    logic [CB-1:0]    dmaj;
    logic [CB:0]      dmin, dmin_abs;
    logic [ACC_W:0]   round_sum;
    logic [CB-1:0]    minor;
    logic             is_last;

    assign accept = cmd_valid & ~cmd_stall;

    // Pick the major axis and order the endpoints
    always_comb
    begin
        dx         = {1'b0, cmd_data.x_end} - {1'b0, cmd_data.x_start};
        dy         = {1'b0, cmd_data.y_end} - {1'b0, cmd_data.y_start};
        adx        = dx[CB] ? -dx : dx;
        ady        = dy[CB] ? -dy : dy;
        x_major_in = adx > ady;
        maj0       = x_major_in ? cmd_data.x_start : cmd_data.y_start;
        maj1       = x_major_in ? cmd_data.x_end   : cmd_data.y_end;
        mn0        = x_major_in ? cmd_data.y_start : cmd_data.x_start;
        mn1        = x_major_in ? cmd_data.y_end   : cmd_data.x_end;
        swap       = maj0 > maj1;
    end

    // Form the distances for the divider
    always_comb
    begin
        dmaj         = major_end_reg - major_pos_reg;
        dmin         = {1'b0, min1_reg} - {1'b0, min0_reg};
        dmin_abs     = dmin[CB] ? -dmin : dmin;
        div_dividend = {dmin_abs[CB-1:0], FRAC_BITS'(0)};
    end

    // Round the minor coordinate, clamping below zero
    always_comb
    begin
        round_sum = {acc_reg[ACC_W-1], acc_reg} + HALF;
        minor     = round_sum[ACC_W] ? '0 : round_sum[FRAC_BITS +: CB];
        is_last   = major_pos_reg >= major_end_reg;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dlr_pkg::ST_IDLE:
            begin
                if (accept && cmd_data.cmd == dlr_pkg::CMD_START)
                begin
                    state_next = dlr_pkg::ST_PREP;
                end
            end
            dlr_pkg::ST_PREP:
            begin
                state_next = (dmaj == '0) ? dlr_pkg::ST_IDLE : dlr_pkg::ST_DIV;
            end
            dlr_pkg::ST_DIV:
            begin
                if (div_status.done)
                begin
                    state_next = dlr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dlr_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        cmd_stall = 1'b1;
        div_start = 1'b0;
        unique case (state_reg)
            dlr_pkg::ST_IDLE:
            begin
                cmd_stall = pix_valid_reg & pix_stall;
            end
            dlr_pkg::ST_PREP:
            begin
                div_start = (dmaj != '0);
            end
            dlr_pkg::ST_DIV:
            begin
                cmd_stall = 1'b1;
            end
            default:
            begin
                cmd_stall = 1'b1;
            end
        endcase
    end

    // Load lines, step pixels and retire pixel beats
    always_comb
    begin
        line_active_next = line_active_reg;
        pix_valid_next   = pix_valid_reg & pix_stall;
        pix_data_next    = pix_data_reg;
        x_major_next     = x_major_reg;
        major_pos_next   = major_pos_reg;
        major_end_next   = major_end_reg;
        min0_next        = min0_reg;
        min1_next        = min1_reg;
        neg_next         = neg_reg;
        acc_next         = acc_reg;
        slope_next       = slope_reg;

        unique case (state_reg)
            dlr_pkg::ST_IDLE:
            begin
                if (accept && cmd_data.cmd == dlr_pkg::CMD_START)
                begin
                    line_active_next = 1'b0;
                    x_major_next     = x_major_in;
                    major_pos_next   = swap ? maj1 : maj0;
                    major_end_next   = swap ? maj0 : maj1;
                    min0_next        = swap ? mn1 : mn0;
                    min1_next        = swap ? mn0 : mn1;
                end
                else if (accept && line_active_reg)
                begin
                    pix_valid_next        = 1'b1;
                    pix_data_next.pixel_x = x_major_reg ? major_pos_reg : minor;
                    pix_data_next.pixel_y = x_major_reg ? minor : major_pos_reg;
                    pix_data_next.last    = is_last;
                    if (is_last)
                    begin
                        line_active_next = 1'b0;
                    end
                    else
                    begin
                        major_pos_next = major_pos_reg + CB'(1);
                        acc_next       = acc_reg + slope_reg;
                    end
                end
            end
            dlr_pkg::ST_PREP:
            begin
                acc_next = {1'b0, min0_reg, FRAC_BITS'(0)};
                neg_next = dmin[CB];
                if (dmaj == '0)
                begin
                    slope_next       = '0;
                    line_active_next = 1'b1;
                end
            end
            dlr_pkg::ST_DIV:
            begin
                if (div_status.done)
                begin
                    slope_next = neg_reg ? -{1'b0, div_quotient} : {1'b0, div_quotient};
                    line_active_next = 1'b1;
                end
            end
            default:
            begin
                line_active_next = 1'b0;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= dlr_pkg::ST_IDLE;
            line_active_reg <= 1'b0;
            pix_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            line_active_reg <= line_active_next;
            pix_valid_reg   <= pix_valid_next;
        end
    end

    // Hold line geometry and the pixel beat
    always_ff @(posedge clk)
    begin
        pix_data_reg  <= pix_data_next;
        x_major_reg   <= x_major_next;
        major_pos_reg <= major_pos_next;
        major_end_reg <= major_end_next;
        min0_reg      <= min0_next;
        min1_reg      <= min1_next;
        neg_reg       <= neg_next;
        acc_reg       <= acc_next;
        slope_reg     <= slope_next;
    end

    dlr_divider #(
        .NUM_BITS (NUM_W),
        .DEN_BITS (CB)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (dmaj),
        .status   (div_status),
        .quotient (div_quotient)
    );

    assign pix_valid = pix_valid_reg;
    assign pix_data  = pix_data_reg;

`ifndef SYNTHESIS
    // A new pixel only comes from a step taken while idle
    a_pix_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pix_valid_reg) |-> $past(state_reg == dlr_pkg::ST_IDLE))
        else $error("pixel beat issued outside idle");

    // Commands are held off while the divider works
    a_stall_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_status.busy |-> cmd_stall)
        else $error("command taken during division");

    // No line is live while its slope is being computed
    a_no_line_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dlr_pkg::ST_DIV) |-> !line_active_reg)
        else $error("line active during division");

    // The major position never passes the end of a live line
    a_major_bound: assert property (@(posedge clk) disable iff (!rst_n)
        line_active_reg |-> (major_pos_reg <= major_end_reg))
        else $error("major position beyond line end");
`endif

endmodule
